// ===== rtl/b64e_pkg.sv =====
// Shared types, constants and character lookup for the base64 encoder.
package b64e_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = 1;
  localparam int unsigned QCntW      = 2;

  // alphabet codes after folding the selector modulo five
  localparam logic [2:0] ALPH_STD    = 3'd0;
  localparam logic [2:0] ALPH_QWERTY = 3'd1;
  localparam logic [2:0] ALPH_URL    = 3'd2;
  localparam logic [2:0] ALPH_LOWER  = 3'd3;
  localparam logic [2:0] ALPH_DIGIT  = 3'd4;

  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

  localparam logic [8*26-1:0] QWERTY_LETTERS = "QWERTYUIOPASDFGHJKLZXCVBNM";

  // one closed group of up to three bytes
  typedef struct packed {
    logic [23:0] triplet;
    logic [1:0]  nbytes;   // 1..3
    logic        last;
  } group_t;

  function automatic logic [2:0] fold_sel(input logic [2:0] sel);
    logic [2:0] r;
    begin
      unique case (sel)
        3'd5:    r = ALPH_STD;
        3'd6:    r = ALPH_QWERTY;
        3'd7:    r = ALPH_URL;
        default: r = sel;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] std_char(input logic [5:0] idx, input logic url);
    logic [7:0] i8;
    logic [7:0] c;
    begin
      i8 = {2'b00, idx};
      if (idx < 6'd26)      c = 8'h41 + i8;
      else if (idx < 6'd52) c = 8'h61 + (i8 - 8'd26);
      else if (idx < 6'd62) c = 8'h30 + (i8 - 8'd52);
      else if (idx == 6'd62) c = url ? 8'h2D : 8'h2B;
      else                  c = url ? 8'h5F : 8'h2F;
      return c;
    end
  endfunction

  function automatic logic [7:0] substitute(input logic [7:0] c);
    logic [7:0] r;
    begin
      unique case (c)
        8'h41:   r = 8'h21;  // A -> !
        8'h5A:   r = 8'h3F;  // Z -> ?
        8'h61:   r = 8'h23;  // a -> #
        8'h7A:   r = 8'h40;  // z -> @
        8'h30:   r = 8'h24;  // 0 -> $
        8'h39:   r = 8'h25;  // 9 -> %
        8'h2B:   r = 8'h26;  // + -> &
        8'h2F:   r = 8'h2A;  // / -> *
        8'h2D:   r = 8'h7E;  // - -> ~
        8'h5F:   r = 8'h5E;  // _ -> ^
        default: r = c;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] lookup_char(input logic [2:0] sel, input logic [5:0] idx);
    logic [2:0] s;
    logic [7:0] i8;
    logic [4:0] li;
    logic [7:0] c;
    begin
      s  = fold_sel(sel);
      i8 = {2'b00, idx};
      li = (idx < 6'd26) ? idx[4:0] : 5'(idx - 6'd26);
      unique case (s)
        ALPH_QWERTY: begin
          if (idx < 6'd26)      c = QWERTY_LETTERS[8*(25 - li) +: 8];
          else if (idx < 6'd52) c = QWERTY_LETTERS[8*(25 - li) +: 8] | 8'h20;
          else                  c = std_char(idx, 1'b0);
        end
        ALPH_URL: c = std_char(idx, 1'b1);
        ALPH_LOWER: begin
          if (idx < 6'd26)      c = 8'h61 + i8;
          else if (idx < 6'd52) c = 8'h41 + (i8 - 8'd26);
          else                  c = std_char(idx, 1'b0);
        end
        ALPH_DIGIT: begin
          if (idx < 6'd10)      c = 8'h30 + i8;
          else if (idx < 6'd36) c = 8'h41 + (i8 - 8'd10);
          else if (idx < 6'd62) c = 8'h61 + (i8 - 8'd36);
          else                  c = std_char(idx, 1'b0);
        end
        default: c = std_char(idx, 1'b0);
      endcase
      return substitute(c);
    end
  endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// Front end: gathers bytes into groups of up to three and closes them.
module b64e_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  output logic                  push,
  output b64e_pkg::group_t      push_group,
  input  logic                  q_full
);

  logic [15:0] held_bytes_r, held_bytes_nxt;
  logic [1:0]  held_count_r, held_count_nxt;
  logic [1:0]  cnt;
  logic [1:0]  nbytes;
  logic        accept;
  logic        closes;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cnt      = (held_count_r == 2'd3) ? 2'd2 : held_count_r;
  assign nbytes   = cnt + 2'd1;
  assign closes   = (nbytes == 2'd3) || in_last_byte;
  assign push     = accept && closes;

  always_comb begin
    push_group.nbytes = nbytes;
    push_group.last   = in_last_byte;
    unique case (nbytes)
      2'd1:    push_group.triplet = {in_data_byte, 16'h0000};
      2'd2:    push_group.triplet = {held_bytes_r[7:0], in_data_byte, 8'h00};
      default: push_group.triplet = {held_bytes_r, in_data_byte};
    endcase
  end

  always_comb begin
    held_bytes_nxt = held_bytes_r;
    held_count_nxt = held_count_r;
    if (accept) begin
      if (closes) begin
        held_bytes_nxt = 16'h0000;
        held_count_nxt = 2'd0;
      end else begin
        held_bytes_nxt = {held_bytes_r[7:0], in_data_byte};
        held_count_nxt = nbytes;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bytes_r <= 16'h0000;
      held_count_r <= 2'd0;
    end else begin
      held_bytes_r <= held_bytes_nxt;
      held_count_r <= held_count_nxt;
    end
  end

endmodule

// ===== rtl/b64e_queue.sv =====
// Two-entry group queue between front and back ends.
module b64e_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  b64e_pkg::group_t      push_group,
  output logic                  full,
  input  logic                  pop,
  output logic                  q_valid,
  output b64e_pkg::group_t      q_group
);

  b64e_pkg::group_t                  entry_r [b64e_pkg::QueueDepth];
  logic [b64e_pkg::QPtrW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [b64e_pkg::QPtrW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [b64e_pkg::QCntW-1:0]        count_r, count_nxt;

  assign full    = (count_r == b64e_pkg::QCntW'(b64e_pkg::QueueDepth));
  assign q_valid = (count_r != '0);
  assign q_group = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_group;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= b64e_pkg::QCntW'(b64e_pkg::QueueDepth))
    else $error("queue count out of range");

endmodule

// ===== rtl/b64e_back.sv =====
// Back end: turns one group into four characters, one per cycle unless stalled.
module b64e_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [2:0]            alphabet_select,
  input  logic                  q_valid,
  input  b64e_pkg::group_t      q_group,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char,
  output logic                  out_last_char
);

  b64e_pkg::group_t cur_r, cur_nxt;
  logic             cur_valid_r, cur_valid_nxt;
  logic [1:0]       k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_load;
  logic             adv;
  logic             adv_last;
  logic [5:0]       sextet;
  logic [7:0]       ch;

  assign out_load = !out_valid_r || !out_stall;
  assign adv      = cur_valid_r && out_load;
  assign adv_last = adv && (k_r == 2'd3);
  assign pop      = q_valid && (!cur_valid_r || adv_last);

  always_comb begin
    unique case (k_r)
      2'd0:    sextet = cur_r.triplet[23:18];
      2'd1:    sextet = cur_r.triplet[17:12];
      2'd2:    sextet = cur_r.triplet[11:6];
      default: sextet = cur_r.triplet[5:0];
    endcase
    // characters past the real bits become padding
    if (k_r <= cur_r.nbytes) ch = b64e_pkg::lookup_char(alphabet_select, sextet);
    else                     ch = b64e_pkg::CHAR_PAD;
  end

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    k_nxt         = k_r;
    if (pop) begin
      cur_nxt       = q_group;
      cur_valid_nxt = 1'b1;
      k_nxt         = 2'd0;
    end else if (adv_last) begin
      cur_valid_nxt = 1'b0;
      k_nxt         = 2'd0;
    end else if (adv) begin
      k_nxt = k_r + 2'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = cur_valid_r;
      out_char_nxt  = ch;
      out_last_nxt  = cur_r.last && (k_r == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

  a_k_idle: assert property (@(posedge clk) disable iff (!rst_n) (k_r != 2'd0) |-> cur_valid_r)
    else $error("character index set with no group held");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_char_r)))
    else $error("stalled word changed");

endmodule

// ===== rtl/base64_encoder_multi_alphabet.sv =====
// Top level of the multi-alphabet base64 encoder.
//
//   channel  direction  handshake            word
//   in       input      in_valid / in_stall  in_data_byte, in_last_byte
//   out      output     out_valid/out_stall  out_char, out_last_char
//   cfg      input      cfg_wr_en            cfg_wr_data (alphabet select)
//
// A byte is taken in any cycle with in_stall low; a group of three (or a short
// final group) is queued; the back end emits its four characters at one per
// cycle unless out_stall is high, so the output port sets the sustained rate.
// A group's first character leaves through the queue, current-group and output registers.
// Reset (synchronous, rst_n low) empties the open group, the queue and the
// output register and selects the standard alphabet.
// out_stall holds the output word; in_stall rises only when the queue is full.
module base64_encoder_multi_alphabet (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last_char,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data
);

  logic [2:0]       alphabet_select_r, alphabet_select_nxt;
  logic             push;
  b64e_pkg::group_t push_group;
  logic             q_full;
  logic             pop;
  logic             q_valid;
  b64e_pkg::group_t q_group;

  assign alphabet_select_nxt = cfg_wr_en ? cfg_wr_data : alphabet_select_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alphabet_select_r <= b64e_pkg::ALPH_STD;
    end else begin
      alphabet_select_r <= alphabet_select_nxt;
    end
  end

  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .push         (push),
    .push_group   (push_group),
    .q_full       (q_full)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_group (push_group),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_group    (q_group)
  );

  b64e_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .alphabet_select (alphabet_select_r),
    .q_valid         (q_valid),
    .q_group         (q_group),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_last_char   (out_last_char)
  );

endmodule

// ===== bench/tb_base64_encoder_multi_alphabet.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the multi-alphabet base64 encoder: predicted characters vs. DUT output.

typedef struct packed {
  logic [7:0] ch;
  logic       last;
} enc_char_t;

class b64_char_board;
  logic [8*64-1:0] alph [5];
  logic [2:0]      sel;
  logic [15:0]     held;
  int unsigned     held_n;
  enc_char_t       due_chars [$];
  int unsigned     errors;

  function new();
    alph[0] = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    alph[1] = "QWERTYUIOPASDFGHJKLZXCVBNMqwertyuiopasdfghjklzxcvbnm0123456789+/";
    alph[2] = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
    alph[3] = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+/";
    alph[4] = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz+/";
    sel     = b64e_pkg::ALPH_STD;
    held    = '0;
    held_n  = 0;
    errors  = 0;
  endfunction

  function void set_alphabet(input logic [2:0] v);
    sel = v;
  endfunction

  function logic [7:0] swap_char(input logic [7:0] c);
    case (c)
      "A":     return "!";
      "Z":     return "?";
      "a":     return "#";
      "z":     return "@";
      "0":     return "$";
      "9":     return "%";
      "+":     return "&";
      "/":     return "*";
      "-":     return "~";
      "_":     return "^";
      default: return c;
    endcase
  endfunction

  // appends the byte to the open group; a full or marked group yields four chars
  function void take_byte(input logic [7:0] b, input logic last);
    logic [23:0] joined;
    logic [23:0] trip;
    logic [5:0]  idx;
    int unsigned n;
    int unsigned s;
    enc_char_t   c;
    joined = {held, b};
    n = ((held_n > 2) ? 2 : held_n) + 1;
    if (n < 3 && !last) begin
      held   = joined[15:0];
      held_n = n;
      return;
    end
    trip = joined << (8 * (3 - n));
    s = sel % 5;
    for (int k = 0; k < 4; k++) begin
      if (k <= n) begin
        idx  = trip[23 - 6*k -: 6];
        c.ch = swap_char(alph[s][8*(63 - idx) +: 8]);
      end else begin
        c.ch = b64e_pkg::CHAR_PAD;  // padding is not substituted
      end
      c.last = last && (k == 3);
      due_chars = {due_chars, c};
    end
    held   = '0;
    held_n = 0;
  endfunction

  function void check_char(input logic [7:0] ch, input logic last);
    enc_char_t e;
    if (due_chars.size() == 0) begin
      $display("%0t: unexpected word char=%h last=%b", $time, ch, last);
      errors++;
      return;
    end
    e = due_chars.pop_front();
    if (ch !== e.ch) begin
      $display("%0t: out_char expected %h actual %h", $time, e.ch, ch);
      errors++;
    end
    if (last !== e.last) begin
      $display("%0t: out_last_char expected %b actual %b", $time, e.last, last);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return due_chars.size();
  endfunction
endclass

module tb_base64_encoder_multi_alphabet;

  // selector values that fold back onto the first three alphabets
  localparam logic [2:0]  SEL_WRAP_STD    = 3'd5;
  localparam logic [2:0]  SEL_WRAP_QWERTY = 3'd6;
  localparam logic [2:0]  SEL_WRAP_URL    = 3'd7;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned SETTLE          = 8;
  localparam int unsigned PHASE_BYTES     = 11;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       out_last_char;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;

  int unsigned   in_idle_pct;
  int unsigned   out_stall_pct;
  longint        cycles;
  b64_char_board board;

  base64_encoder_multi_alphabet u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_last_char(out_last_char),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_char(out_char, out_last_char);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_base64_encoder_multi_alphabet NOT OK");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = b;
    in_last_byte = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte(b, last);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_alphabet(input logic [2:0] v);
    drain_results();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    board.set_alphabet(v);
  endtask

  // message always closes on its final word; noisy ones also close groups early
  task automatic send_message(input int unsigned len, input bit noisy);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)),
                (i == len - 1) || (noisy && $urandom_range(3) == 0));
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    bit          paused;
    logic [2:0]  phase_sel [8];
    phase_sel = '{b64e_pkg::ALPH_STD, b64e_pkg::ALPH_QWERTY, SEL_WRAP_URL,
                  b64e_pkg::ALPH_LOWER, b64e_pkg::ALPH_DIGIT, SEL_WRAP_STD,
                  b64e_pkg::ALPH_URL, SEL_WRAP_QWERTY};
    board         = new();
    cycles        = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_last_byte  = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: single and double byte groups with padding, extremes, all substitutions
    write_alphabet(b64e_pkg::ALPH_STD);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // indices 25 26 51 52, then 61 62 63 0
    send_byte(8'h65, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hC0, 1'b1);
    write_alphabet(b64e_pkg::ALPH_URL);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hC0, 1'b1);

    for (int p = 0; p < 8; p++) begin
      write_alphabet(phase_sel[p]);
      in_idle_pct   = (p % 4 == 1) ? 72 : (p % 4 == 3) ? 22 : 0;
      out_stall_pct = (p % 4 == 2) ? 72 : (p % 4 == 3) ? 22 : 0;
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_BYTES) begin
        if (!paused && sent >= 4) begin
          drain_results();
          paused = 1'b1;
        end
        len = ($urandom_range(4) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
        send_message(len, $urandom_range(5) == 0);
        sent += len;
      end
    end

    in_valid      = 1'b0;
    in_idle_pct   = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_base64_encoder_multi_alphabet OK");
    end else begin
      $display("tb_base64_encoder_multi_alphabet NOT OK");
    end
    $finish;
  end
endmodule
